@@ rtl/sdti_pkg.sv @@
// Package for the square-root domain table interpolator.
// Holds widths, table depth, status codes, state types, the queue item struct and the
// arithmetic request and response structs. No dependencies.
package sdti_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = 9;
    localparam int TIME_W      = 32;
    localparam int POWER_W     = 48;
    localparam int ROOT_W      = 32;
    localparam int PROD_W      = 64;

    // Result status codes
    typedef enum logic [1:0] {
        ST_INTERP = 2'd0,
        ST_LAST   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_SAT    = 2'd3
    } t_status;

    // One queued transaction, already classified by the front end
    typedef struct packed {
        logic                is_query;
        logic [IDX_W-1:0]    idx;
        logic [TIME_W-1:0]   etime;
        logic [POWER_W-1:0]  epower;
        logic [TIME_W-1:0]   qtime;
    } t_item;

    // Request to the arithmetic unit
    typedef struct packed {
        logic                start;
        logic [POWER_W-1:0]  p0;
        logic [POWER_W-1:0]  p1;
        logic [TIME_W-1:0]   d;
        logic [TIME_W-1:0]   n;
    } t_ar_req;

    // Response from the arithmetic unit
    typedef struct packed {
        logic                done;
        logic                sat;
        logic [POWER_W-1:0]  power;
    } t_ar_rsp;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_CHECK,
        B_MATH
    } t_back_state;

    typedef enum logic [3:0] {
        AR_IDLE,
        AR_SQRT0,
        AR_SQRT1,
        AR_MUL0,
        AR_MUL1,
        AR_SUM,
        AR_DIV,
        AR_SQR,
        AR_RND
    } t_ar_state;

endpackage

@@ rtl/sqrt_domain_table_interpolator_top.sv @@
// Top level of the square-root domain table interpolator.
// Depends on sdti_pkg, sdti_front and sdti_back.
//
// A load transaction writes one (time, power) entry in the back end and gives no result.
// A query scans the table with one memory read and one compare per entry; when an interval
// matches, the arithmetic unit runs two bit-serial square roots, the bit-serial divider
// and the shared 32x32 multiplier.
// Transactions are queued two deep ahead of the back end; busy is high while the queue is
// full. Each result appears on o_done for one cycle and cannot be stalled.
module sqrt_domain_table_interpolator_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_cfg_we,
    input  logic [sdti_pkg::CNT_W-1:0]   i_cfg_data,
    input  logic                         i_mode,
    input  logic [sdti_pkg::IDX_W-1:0]   i_entry_index,
    input  logic [sdti_pkg::TIME_W-1:0]  i_entry_time,
    input  logic [sdti_pkg::POWER_W-1:0] i_entry_power,
    input  logic [sdti_pkg::TIME_W-1:0]  i_query_time,
    output logic                         o_done,
    output logic [sdti_pkg::POWER_W-1:0] o_expected_power,
    output logic [1:0]                   o_query_status
);

    logic [sdti_pkg::CNT_W-1:0] r_num_entries;
    logic            pop, nempty;
    sdti_pkg::t_item head;

    // entry count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_num_entries <= '0;
        else if (i_cfg_we) r_num_entries <= i_cfg_data;
    end

    sdti_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (start),
        .i_mode        (i_mode),
        .i_entry_index (i_entry_index),
        .i_entry_time  (i_entry_time),
        .i_entry_power (i_entry_power),
        .i_query_time  (i_query_time),
        .i_pop         (pop),
        .o_full        (busy),
        .o_nempty      (nempty),
        .o_head        (head)
    );

    sdti_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_num_entries    (r_num_entries),
        .i_nempty         (nempty),
        .i_head           (head),
        .o_pop            (pop),
        .o_done           (o_done),
        .o_expected_power (o_expected_power),
        .o_query_status   (o_query_status)
    );

endmodule

@@ rtl/sdti_front.sv @@
// Front end: accepts transactions, tags them as load or query, queues them.
// Depends on sdti_pkg.
module sdti_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic                         i_mode,
    input  logic [sdti_pkg::IDX_W-1:0]   i_entry_index,
    input  logic [sdti_pkg::TIME_W-1:0]  i_entry_time,
    input  logic [sdti_pkg::POWER_W-1:0] i_entry_power,
    input  logic [sdti_pkg::TIME_W-1:0]  i_query_time,
    input  logic                         i_pop,
    output logic                         o_full,
    output logic                         o_nempty,
    output sdti_pkg::t_item              o_head
);

    sdti_pkg::t_item r_q [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    logic            do_push, do_pop;

    assign o_full   = (r_cnt == 2'd2);
    assign o_nempty = (r_cnt != 2'd0);
    assign o_head   = r_q[r_rp];
    assign do_push  = i_push && !o_full;
    assign do_pop   = i_pop && o_nempty;

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    // queue storage, classified on entry
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp].is_query <= i_mode;
            r_q[r_wp].idx      <= i_entry_index;
            r_q[r_wp].etime    <= i_entry_time;
            r_q[r_wp].epower   <= i_entry_power;
            r_q[r_wp].qtime    <= i_query_time;
        end
    end

endmodule

@@ rtl/sdti_arith.sv @@
// Arithmetic unit: two square roots, linear blend, division, squaring with rounding.
// Iterative, one root or quotient bit per cycle, one shared 32x32 multiplier. Uses sdti_pkg.
module sdti_arith (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sdti_pkg::t_ar_req i_req,
    output sdti_pkg::t_ar_rsp o_rsp
);

    sdti_pkg::t_ar_state r_state, n_state;
    logic [5:0]  r_cnt;
    logic [63:0] r_rad;
    logic [33:0] r_rem;
    logic [31:0] r_root, r_r0, r_r1;
    logic [47:0] r_p1;
    logic [31:0] r_d, r_n;
    logic [63:0] r_prod, r_acc, r_dvd;
    logic [31:0] r_drem;
    logic        r_done, r_sat;
    logic [47:0] r_power;

    logic [35:0] rem_sh, trial;
    logic        sq_ge;
    logic [33:0] n_rem;
    logic [31:0] n_root;
    logic [32:0] div_sh;
    logic        div_ge;
    logic [31:0] n_drem;
    logic [31:0] mul_a, mul_b;
    logic [64:0] rnd_sum;
    logic [48:0] rnd_pw;
    logic        last_bit, sqrt_step, mul_en;

    // square-root step: two radicand bits in, one root bit out
    assign rem_sh = {r_rem, r_rad[63:62]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign sq_ge  = (rem_sh >= trial);
    assign n_rem  = sq_ge ? 34'(rem_sh - trial) : rem_sh[33:0];
    assign n_root = {r_root[30:0], sq_ge};

    // restoring division step
    assign div_sh = {r_drem, r_dvd[63]};
    assign div_ge = (div_sh >= {1'b0, r_d});
    assign n_drem = div_ge ? 32'(div_sh - {1'b0, r_d}) : div_sh[31:0];

    // rounding of the square
    assign rnd_sum = {1'b0, r_prod} + 65'd32768;
    assign rnd_pw  = rnd_sum[64:16];

    assign last_bit = (r_state == sdti_pkg::AR_DIV) ? (r_cnt == 6'd63) : (r_cnt == 6'd31);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sdti_pkg::AR_IDLE:  if (i_req.start) n_state = sdti_pkg::AR_SQRT0;
            sdti_pkg::AR_SQRT0: if (last_bit) n_state = sdti_pkg::AR_SQRT1;
            sdti_pkg::AR_SQRT1: if (last_bit) n_state = sdti_pkg::AR_MUL0;
            sdti_pkg::AR_MUL0:  n_state = sdti_pkg::AR_MUL1;
            sdti_pkg::AR_MUL1:  n_state = sdti_pkg::AR_SUM;
            sdti_pkg::AR_SUM:   n_state = sdti_pkg::AR_DIV;
            sdti_pkg::AR_DIV:   if (last_bit) n_state = sdti_pkg::AR_SQR;
            sdti_pkg::AR_SQR:   n_state = sdti_pkg::AR_RND;
            sdti_pkg::AR_RND:   n_state = sdti_pkg::AR_IDLE;
            default:            n_state = sdti_pkg::AR_IDLE;
        endcase
    end

    // datapath controls and multiplier operands
    always_comb begin
        sqrt_step = 1'b0;
        mul_en    = 1'b0;
        mul_a     = r_r0;
        mul_b     = 32'(r_d - r_n);
        unique case (r_state)
            sdti_pkg::AR_SQRT0, sdti_pkg::AR_SQRT1: sqrt_step = 1'b1;
            sdti_pkg::AR_MUL0: mul_en = 1'b1;
            sdti_pkg::AR_MUL1: begin
                mul_en = 1'b1;
                mul_a  = r_r1;
                mul_b  = r_n;
            end
            sdti_pkg::AR_SQR: begin
                mul_en = 1'b1;
                mul_a  = r_dvd[31:0];
                mul_b  = r_dvd[31:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdti_pkg::AR_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == sdti_pkg::AR_RND);
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (mul_en) r_prod <= 64'(mul_a) * 64'(mul_b);
        // last step of the first root reloads for the second one below
        if (sqrt_step && !(r_state == sdti_pkg::AR_SQRT0 && last_bit)) begin
            r_rad  <= {r_rad[61:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= n_root;
            r_cnt  <= r_cnt + 6'd1;
        end
        unique case (r_state)
            sdti_pkg::AR_IDLE: begin
                if (i_req.start) begin
                    r_rad  <= {i_req.p0, 16'h0000};
                    r_p1   <= i_req.p1;
                    r_d    <= i_req.d;
                    r_n    <= i_req.n;
                    r_rem  <= '0;
                    r_root <= '0;
                    r_cnt  <= '0;
                end
            end
            sdti_pkg::AR_SQRT0: begin
                if (last_bit) begin
                    r_r0   <= n_root;
                    r_rad  <= {r_p1, 16'h0000};
                    r_rem  <= '0;
                    r_root <= '0;
                    r_cnt  <= '0;
                end
            end
            sdti_pkg::AR_SQRT1: if (last_bit) r_r1 <= n_root;
            sdti_pkg::AR_MUL1:  r_acc <= r_prod + 64'(r_d >> 1);
            sdti_pkg::AR_SUM: begin
                r_dvd  <= r_acc + r_prod;
                r_drem <= '0;
                r_cnt  <= '0;
            end
            sdti_pkg::AR_DIV: begin
                r_dvd  <= {r_dvd[62:0], div_ge};
                r_drem <= n_drem;
                r_cnt  <= r_cnt + 6'd1;
            end
            sdti_pkg::AR_RND: begin
                r_sat   <= rnd_pw[48];
                r_power <= rnd_pw[48] ? {48{1'b1}} : rnd_pw[47:0];
            end
            default: ;
        endcase
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.sat   = r_sat;
    assign o_rsp.power = r_power;

endmodule

@@ rtl/sdti_back.sv @@
// Back end: table memory, interval search, result register.
// Depends on sdti_pkg and sdti_arith.
module sdti_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [sdti_pkg::CNT_W-1:0]   i_num_entries,
    input  logic                         i_nempty,
    input  sdti_pkg::t_item              i_head,
    output logic                         o_pop,
    output logic                         o_done,
    output logic [sdti_pkg::POWER_W-1:0] o_expected_power,
    output logic [1:0]                   o_query_status
);

    localparam int ENT_W = sdti_pkg::TIME_W + sdti_pkg::POWER_W;

    sdti_pkg::t_back_state r_state, n_state;

    logic [ENT_W-1:0] mem [sdti_pkg::TABLE_DEPTH];
    logic [ENT_W-1:0] r_rd;

    logic [sdti_pkg::CNT_W-1:0]   r_neff, r_k, neff;
    logic [sdti_pkg::TIME_W-1:0]  r_q, r_prev_t, rd_t;
    logic [sdti_pkg::POWER_W-1:0] r_prev_p, rd_p;
    logic                         r_done;
    logic [sdti_pkg::POWER_W-1:0] r_power;
    sdti_pkg::t_status            r_status;

    logic              mem_we, match, at_last;
    logic              res_en;
    logic [sdti_pkg::POWER_W-1:0] res_power;
    sdti_pkg::t_status res_status;
    sdti_pkg::t_ar_req ar_req;
    sdti_pkg::t_ar_rsp ar_rsp;

    assign neff  = (i_num_entries > sdti_pkg::CNT_W'(sdti_pkg::TABLE_DEPTH))
                 ? sdti_pkg::CNT_W'(sdti_pkg::TABLE_DEPTH) : i_num_entries;
    assign rd_t  = r_rd[ENT_W-1 -: sdti_pkg::TIME_W];
    assign rd_p  = r_rd[sdti_pkg::POWER_W-1:0];
    assign match = (r_k != '0) && (r_q > r_prev_t) && (r_q <= rd_t);
    assign at_last = (r_k == r_neff - sdti_pkg::CNT_W'(1));

    // table memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[i_head.idx] <= {i_head.etime, i_head.epower};
        r_rd <= mem[r_k[sdti_pkg::IDX_W-1:0]];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sdti_pkg::B_IDLE:
                if (i_nempty && i_head.is_query && neff != '0) n_state = sdti_pkg::B_READ;
            sdti_pkg::B_READ:  n_state = sdti_pkg::B_CHECK;
            sdti_pkg::B_CHECK: begin
                if (match)        n_state = sdti_pkg::B_MATH;
                else if (at_last) n_state = sdti_pkg::B_IDLE;
                else              n_state = sdti_pkg::B_READ;
            end
            sdti_pkg::B_MATH:  if (ar_rsp.done) n_state = sdti_pkg::B_IDLE;
            default:           n_state = sdti_pkg::B_IDLE;
        endcase
    end

    // outputs of the search controller
    always_comb begin
        o_pop        = 1'b0;
        mem_we       = 1'b0;
        res_en       = 1'b0;
        res_power    = rd_p;
        res_status   = sdti_pkg::ST_LAST;
        ar_req.start = 1'b0;
        ar_req.p0    = r_prev_p;
        ar_req.p1    = rd_p;
        ar_req.d     = rd_t - r_prev_t;
        ar_req.n     = r_q - r_prev_t;
        unique case (r_state)
            sdti_pkg::B_IDLE: begin
                o_pop  = i_nempty;
                mem_we = i_nempty && !i_head.is_query;
                if (i_nempty && i_head.is_query && neff == '0) begin
                    res_en     = 1'b1;
                    res_power  = '0;
                    res_status = sdti_pkg::ST_EMPTY;
                end
            end
            sdti_pkg::B_CHECK: begin
                ar_req.start = match;
                res_en       = !match && at_last;
            end
            sdti_pkg::B_MATH: begin
                res_en     = ar_rsp.done;
                res_power  = ar_rsp.power;
                res_status = ar_rsp.sat ? sdti_pkg::ST_SAT : sdti_pkg::ST_INTERP;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdti_pkg::B_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= res_en;
        end
    end

    // scan registers and result
    always_ff @(posedge i_clk) begin
        if (r_state == sdti_pkg::B_IDLE) begin
            r_k    <= '0;
            r_neff <= neff;
            r_q    <= i_head.qtime;
        end
        if (r_state == sdti_pkg::B_CHECK && !match) begin
            r_k      <= r_k + sdti_pkg::CNT_W'(1);
            r_prev_t <= rd_t;
            r_prev_p <= rd_p;
        end
        if (res_en) begin
            r_power  <= res_power;
            r_status <= res_status;
        end
    end

    sdti_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ar_req),
        .o_rsp   (ar_rsp)
    );

    assign o_done           = r_done;
    assign o_expected_power = r_power;
    assign o_query_status   = r_status;

endmodule

@@ rtl/sdti_checker.sv @@
// Port-level checker for the interpolator top level, bound to it below.
// Depends on sdti_pkg.
module sdti_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_done,
    input logic [sdti_pkg::POWER_W-1:0] o_expected_power,
    input logic [1:0]                   o_query_status
);

    // no result right after reset
    a_no_done_after_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_done)
        else $error("result strobe after reset");

    // busy only rises after a transaction was offered
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a transaction");

    // empty-table answers are zero
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_query_status == sdti_pkg::ST_EMPTY) |-> (o_expected_power == '0))
        else $error("empty table gave nonzero power");

    // saturated answers are full scale
    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_query_status == sdti_pkg::ST_SAT) |-> (&o_expected_power))
        else $error("saturated power not full scale");

endmodule

bind sqrt_domain_table_interpolator_top sdti_checker u_sdti_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_done           (o_done),
    .o_expected_power (o_expected_power),
    .o_query_status   (o_query_status)
);
